// ===== sv/tcs_pkg.sv =====
// Package for the text column glyph segmenter.
// Holds the transaction payload types, register codes and row search functions.
// No dependencies.
package tcs_pkg;

  localparam int unsigned MaskW       = 32;  // rows carried by one pixel column
  localparam int unsigned RowW        = 5;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned BoxLeftW    = 10;
  localparam int unsigned BoxWidthW   = 10;
  localparam int unsigned BoxHeightW  = 6;
  localparam int unsigned GapLimW     = 10;  // holds ten times the largest gap unit
  localparam int unsigned CfgIdxW     = 2;
  localparam logic [CfgW-1:0] MaxRows = CfgW'(MaskW);

  localparam logic [CfgW-1:0] LineHeightRst = 6'd16;
  localparam logic [CfgW-1:0] GapUnitRst    = 6'd4;
  localparam logic [CfgW-1:0] ImageRowsRst  = 6'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineHeight = 2'd0,
    CfgGapUnit    = 2'd1,
    CfgImageRows  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [MaskW-1:0] dark_mask;
    logic             last_column;
  } column_t;

  typedef struct packed {
    logic [BoxLeftW-1:0]   box_left;
    logic [RowW-1:0]       box_top;
    logic [BoxWidthW-1:0]  box_width;
    logic [BoxHeightW-1:0] box_height;
  } box_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [CfgW-1:0]    wr_data;
  } cfg_wr_t;

  // Per-frame glyph tracking flags and rows.
  typedef struct packed {
    logic            open;
    logic [RowW-1:0] top;
    logic [RowW-1:0] bottom;
    logic            seen_box;
    logic            stopped;
  } glyph_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [RowW-1:0] lowest_set(input logic [MaskW-1:0] m);
    logic [RowW-1:0] idx;
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) idx = RowW'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit; zero when none is set.
  function automatic logic [RowW-1:0] highest_set(input logic [MaskW-1:0] m);
    logic [RowW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (m[i]) idx = RowW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== sv/tcs_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// The payload type is set per instance; no package dependency.
interface tcs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tcs_column_logic.sv =====
// Combinational update of the glyph tracker for one pixel column.
// Depends on tcs_pkg.
module tcs_column_logic #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned ColW        = $clog2(MAX_COLUMNS + 1)
) (
  input  logic [tcs_pkg::CfgW-1:0]  line_height_i,
  input  logic [tcs_pkg::CfgW-1:0]  gap_unit_i,
  input  logic [tcs_pkg::CfgW-1:0]  image_rows_i,
  input  tcs_pkg::column_t          column_i,
  input  logic [ColW-1:0]           col_idx_i,
  input  logic [ColW-1:0]           left_i,
  input  logic [ColW-1:0]           last_box_i,
  input  tcs_pkg::glyph_t           glyph_i,
  output logic [ColW-1:0]           col_idx_o,
  output logic [ColW-1:0]           left_o,
  output logic [ColW-1:0]           last_box_o,
  output tcs_pkg::glyph_t           glyph_o,
  output logic                      emit_o,
  output tcs_pkg::box_t             box_o
);
  import tcs_pkg::*;

  localparam int unsigned CmpW = (ColW > GapLimW) ? ColW : GapLimW;
  localparam logic [ColW-1:0] ColLimit = ColW'(MAX_COLUMNS);

  logic               skip;
  logic               stop_now;
  logic               active;
  logic [ColW-1:0]    since_box;
  logic [GapLimW-1:0] gap_limit;
  logic [CfgW-1:0]    rows;
  logic [MaskW-1:0]   row_mask;
  logic [MaskW-1:0]   dark;
  logic               any_dark;
  logic [RowW-1:0]    first_row;
  logic [RowW-1:0]    new_top;
  logic [RowW-1:0]    base_bottom;
  logic [RowW+1:0]    reach;
  logic [MaskW-1:0]   reach_mask;
  logic [MaskW-1:0]   reach_dark;
  logic [RowW-1:0]    far_row;
  logic [RowW-1:0]    new_bottom;

  always_comb begin
    skip      = glyph_i.stopped || (col_idx_i >= ColLimit);
    since_box = col_idx_i - last_box_i;
    gap_limit = (GapLimW'(gap_unit_i) << 3) + (GapLimW'(gap_unit_i) << 1);
    stop_now  = !skip && glyph_i.seen_box && (CmpW'(since_box) > CmpW'(gap_limit));
    active    = !skip && !stop_now;

    rows     = (image_rows_i > MaxRows) ? MaxRows : image_rows_i;
    row_mask = {MaskW{1'b1}} >> (MaxRows - rows);
    dark     = column_i.dark_mask & row_mask;
    any_dark = |dark;

    // Rows above the old top only lower the top; the bottom grows from rows
    // below the old bottom that lie within line_height of the new top.
    first_row   = lowest_set(dark);
    new_top     = (glyph_i.open && (glyph_i.top < first_row)) ? glyph_i.top : first_row;
    base_bottom = glyph_i.open ? glyph_i.bottom : first_row;
    reach       = (RowW + 2)'(new_top) + (RowW + 2)'(line_height_i);
    reach_mask  = (reach >= (RowW + 2)'(MaskW)) ? {MaskW{1'b1}}
                                                 : ((MaskW'(1) << reach[RowW-1:0]) - 1'b1);
    reach_dark  = dark & reach_mask;
    far_row     = highest_set(reach_dark);
    new_bottom  = ((|reach_dark) && (far_row > base_bottom)) ? far_row : base_bottom;

    emit_o = active && !any_dark && glyph_i.open;

    box_o.box_left   = BoxLeftW'(left_i);
    box_o.box_top    = glyph_i.top;
    box_o.box_width  = BoxWidthW'(col_idx_i - left_i);
    box_o.box_height = BoxHeightW'(BoxHeightW'(glyph_i.bottom) - BoxHeightW'(glyph_i.top)
                                   + BoxHeightW'(1));

    col_idx_o  = col_idx_i;
    left_o     = left_i;
    last_box_o = last_box_i;
    glyph_o    = glyph_i;

    if (stop_now) glyph_o.stopped = 1'b1;

    if (active && any_dark) begin
      glyph_o.open   = 1'b1;
      glyph_o.top    = new_top;
      glyph_o.bottom = new_bottom;
      if (!glyph_i.open) left_o = col_idx_i;
    end else if (emit_o) begin
      glyph_o.open     = 1'b0;
      glyph_o.top      = '0;
      glyph_o.bottom   = '0;
      glyph_o.seen_box = 1'b1;
      left_o           = '0;
      last_box_o       = col_idx_i;
    end

    if (col_idx_i < ColLimit) col_idx_o = col_idx_i + 1'b1;

    if (column_i.last_column) begin
      col_idx_o  = '0;
      left_o     = '0;
      last_box_o = '0;
      glyph_o    = '0;
    end
  end

endmodule

// ===== sv/text_column_char_segmenter.sv =====
// Top level of the text column glyph segmenter: channel registers, settings, tracker state.
// Depends on tcs_pkg, tcs_stream_if and tcs_column_logic.
//
//   channel  dir  payload                                        transaction
//   cfg_i    in   reg_index, wr_data                             settings write
//   col_i    in   dark_mask, last_column                         one pixel column
//   box_o    out  box_left, box_top, box_width, box_height       one closed glyph box
//
// One column per cycle while the result register is free or draining: a column is held in the
// input register and resolved by the tracker as it moves on, so a box enters the result register
// as its closing column moves on. cfg_i is always ready and takes effect next cycle.
// A box waiting in the output register stalls the input register, and col_i.ready
// then drops; nothing is lost or repeated. Reset clears the tracker, the
// channel valids and returns the settings to their defaults.
module text_column_char_segmenter #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcs_stream_if.sink       cfg_i,
  tcs_stream_if.sink       col_i,
  tcs_stream_if.source     box_o
);
  import tcs_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLUMNS + 1);

  // settings
  logic [CfgW-1:0] line_height_q;
  logic [CfgW-1:0] gap_unit_q;
  logic [CfgW-1:0] image_rows_q;

  // input register
  logic    in_valid_q;
  column_t in_col_q;
  logic    advance;

  // tracker state
  logic [ColW-1:0] col_idx_q, col_idx_d;
  logic [ColW-1:0] left_q, left_d;
  logic [ColW-1:0] last_box_q, last_box_d;
  glyph_t          glyph_q, glyph_d;

  // result register
  logic emit;
  box_t box_d;
  logic out_valid_q;
  box_t out_box_q;

  // Move the held column on when the result register is free or being drained.
  assign advance     = in_valid_q && (!out_valid_q || box_o.ready);
  assign col_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_height_q <= LineHeightRst;
      gap_unit_q    <= GapUnitRst;
      image_rows_q  <= ImageRowsRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        CfgLineHeight: line_height_q <= cfg_i.data.wr_data;
        CfgGapUnit:    gap_unit_q    <= cfg_i.data.wr_data;
        CfgImageRows:  image_rows_q  <= cfg_i.data.wr_data;
        default: ;     // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (col_i.ready) begin
      in_valid_q <= col_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_i.valid && col_i.ready) begin
      in_col_q <= col_i.data;
    end
  end

  tcs_column_logic #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ColW        (ColW)
  ) u_column_logic (
    .line_height_i (line_height_q),
    .gap_unit_i    (gap_unit_q),
    .image_rows_i  (image_rows_q),
    .column_i      (in_col_q),
    .col_idx_i     (col_idx_q),
    .left_i        (left_q),
    .last_box_i    (last_box_q),
    .glyph_i       (glyph_q),
    .col_idx_o     (col_idx_d),
    .left_o        (left_d),
    .last_box_o    (last_box_d),
    .glyph_o       (glyph_d),
    .emit_o        (emit),
    .box_o         (box_d)
  );

  // Commit the tracker only when the column actually moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q  <= '0;
      left_q     <= '0;
      last_box_q <= '0;
      glyph_q    <= '0;
    end else if (advance) begin
      col_idx_q  <= col_idx_d;
      left_q     <= left_d;
      last_box_q <= last_box_d;
      glyph_q    <= glyph_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (box_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_box_q <= box_d;
    end
  end

  assign box_o.valid = out_valid_q;
  assign box_o.data  = out_box_q;

  // A finished frame leaves the tracker at its reset point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_col_q.last_column) |=> (col_idx_q == '0 && !glyph_q.open && !glyph_q.seen_box))
    else $error("tracker not cleared after last column");

  // The scan only stops after at least one box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_q.stopped |-> glyph_q.seen_box)
    else $error("scan stopped without a box");

  // An open glyph never has its bottom above its top.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_q.open |-> (glyph_q.bottom >= glyph_q.top))
    else $error("glyph bottom above top");

  // A box is only produced for an open glyph, and has a non-zero height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (box_o.valid && box_o.data.box_height != '0))
    else $error("emitted box lost or has zero height");

  // The column counter saturates at the column limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_idx_q <= ColW'(MAX_COLUMNS))
    else $error("column counter out of range");

endmodule

// ===== sim/tb_text_column_char_segmenter.sv =====
// Self-checking testbench for text_column_char_segmenter: column stream in, glyph boxes out.
// Depends on tcs_pkg, tcs_stream_if and the segmenter RTL; boxes are predicted in-bench.
// Directed table first, then random frames under several register settings.
module tb_text_column_char_segmenter;
  import tcs_pkg::*;

  localparam int unsigned MaxCols    = 1024;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned GapStop    = 10;   // gap units after the last box that end a scan
  localparam int unsigned RandItems  = 1550;

  // How a directed row is checked: by the in-bench tracker, against a typed box, or not at all.
  typedef enum logic [1:0] {
    ChkModel,
    ChkNone,
    ChkBox
  } check_e;

  typedef struct {
    logic [31:0] mask;
    logic        last;
    check_e      chk;
    box_t        box;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  tcs_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();
  tcs_stream_if #(.payload_t(column_t)) col_if ();
  tcs_stream_if #(.payload_t(box_t))    box_if ();

  text_column_char_segmenter #(
    .MAX_COLUMNS(MaxCols)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .col_i (col_if),
    .box_o (box_if)
  );

  // Register copies, updated when a settings transaction is accepted.
  logic [CfgW-1:0] cfg_line_height;
  logic [CfgW-1:0] cfg_gap_unit;
  logic [CfgW-1:0] cfg_image_rows;

  // Glyph tracker state of the predictor.
  int trk_col;
  bit trk_open;
  int trk_left;
  int trk_top;
  int trk_bottom;
  bit trk_seen;
  int trk_last_box;
  bit trk_stopped;

  box_t pending_boxes [$];   // boxes predicted but not yet seen on box_o
  int   err_count;
  int   cycle_count;
  int   rx_stall;
  bit   calm;                // frame runs with no idling on either side
  box_t got_box;

  // Default settings: line height 16, gap unit 4, all 32 rows.
  dir_row_t directed_rows [16] = '{
    '{32'h0000_0000, 1'b0, ChkNone,  '0},
    '{32'hFFFF_FFFF, 1'b0, ChkNone,  '0},                           // full column, bottom held at 15
    '{32'h0000_0000, 1'b0, ChkBox,   '{10'd1, 5'd0, 10'd1, 6'd16}},
    '{32'h8000_0000, 1'b0, ChkNone,  '0},                           // opens at the last row
    '{32'h0000_0001, 1'b0, ChkNone,  '0},                           // top rises to row 0
    '{32'h0000_0000, 1'b0, ChkBox,   '{10'd3, 5'd0, 10'd2, 6'd32}},
    '{32'h0000_0F00, 1'b0, ChkNone,  '0},
    '{32'h0000_0000, 1'b1, ChkBox,   '{10'd6, 5'd8, 10'd1, 6'd4}},  // final column closes it
    '{32'h0000_FFFF, 1'b0, ChkNone,  '0},
    '{32'h0000_FFFF, 1'b1, ChkNone,  '0},                           // open at frame end: dropped
    '{32'h0000_0000, 1'b0, ChkNone,  '0},
    '{32'h0001_0000, 1'b0, ChkModel, '0},
    '{32'h0000_0002, 1'b0, ChkModel, '0},
    '{32'hFFFF_FFFF, 1'b0, ChkModel, '0},
    '{32'h0000_0000, 1'b0, ChkModel, '0},
    '{32'h0000_0000, 1'b1, ChkNone,  '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run: a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_text_column_char_segmenter: FAIL");
      $finish;
    end
  end

  // Clear the per-frame tracker, as after reset and after a final column.
  function automatic void clear_tracker();
    trk_col      = 0;
    trk_open     = 1'b0;
    trk_left     = 0;
    trk_top      = 0;
    trk_bottom   = 0;
    trk_seen     = 1'b0;
    trk_last_box = 0;
    trk_stopped  = 1'b0;
  endfunction

  // Advance the tracker by one column; return 1 with the box when a glyph closes.
  function automatic bit segment_column(input logic [31:0] mask, input logic last,
                                        output box_t bx);
    int nrows;
    bit any_dark;
    bit hit;
    hit      = 1'b0;
    any_dark = 1'b0;
    bx       = '0;
    if (!trk_stopped && trk_col < int'(MaxCols)) begin
      // The stop test comes first: a dark column past the gap limit is ignored too.
      if (trk_seen && (trk_col - trk_last_box) > int'(GapStop) * int'(cfg_gap_unit)) begin
        trk_stopped = 1'b1;
      end else begin
        nrows = (int'(cfg_image_rows) < int'(MaskW)) ? int'(cfg_image_rows) : int'(MaskW);
        for (int y = 0; y < nrows; y++) begin
          if (mask[y]) begin
            any_dark = 1'b1;
            if (!trk_open) begin
              // First dark row of a new glyph is both its top and its bottom.
              trk_open   = 1'b1;
              trk_left   = trk_col;
              trk_top    = y;
              trk_bottom = y;
            end else begin
              if (y < trk_top) trk_top = y;
              if (y > trk_bottom && y < trk_top + int'(cfg_line_height)) trk_bottom = y;
            end
          end
        end
        if (!any_dark && trk_open) begin
          bx.box_left   = BoxLeftW'(trk_left);
          bx.box_top    = RowW'(trk_top);
          bx.box_width  = BoxWidthW'(trk_col - trk_left);
          bx.box_height = BoxHeightW'(trk_bottom - trk_top + 1);
          hit           = 1'b1;
          trk_seen      = 1'b1;
          trk_last_box  = trk_col;
          trk_open      = 1'b0;
          trk_left      = 0;
          trk_top       = 0;
          trk_bottom    = 0;
        end
      end
    end
    if (trk_col < int'(MaxCols)) trk_col++;
    if (last) clear_tracker();
    return hit;
  endfunction

  // Box sink: draw a stall per box, compare each transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        got_box = box_if.data;
        if (pending_boxes.size() == 0) begin
          $error("unexpected box: left %0d top %0d width %0d height %0d",
                 got_box.box_left, got_box.box_top, got_box.box_width, got_box.box_height);
          err_count++;
        end else begin
          automatic box_t want = pending_boxes.pop_front();
          if (got_box.box_left !== want.box_left) begin
            $error("box_left: expected %0d, got %0d", want.box_left, got_box.box_left);
            err_count++;
          end
          if (got_box.box_top !== want.box_top) begin
            $error("box_top: expected %0d, got %0d", want.box_top, got_box.box_top);
            err_count++;
          end
          if (got_box.box_width !== want.box_width) begin
            $error("box_width: expected %0d, got %0d", want.box_width, got_box.box_width);
            err_count++;
          end
          if (got_box.box_height !== want.box_height) begin
            $error("box_height: expected %0d, got %0d", want.box_height, got_box.box_height);
            err_count++;
          end
        end
        rx_stall = calm ? 0 : $urandom_range(0, 7);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      box_if.ready <= (rx_stall == 0);
    end
  end

  // Offer one column after a random gap; hold it until accepted, then predict.
  task automatic send_column(input logic [31:0] mask, input logic last, input check_e chk,
                             input box_t typed);
    int   gap;
    bit   hit;
    box_t bx;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      col_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    col_if.valid <= 1'b1;
    col_if.data  <= '{dark_mask: mask, last_column: last};
    do @(posedge clk_i); while (!col_if.ready);
    hit = segment_column(mask, last, bx);
    case (chk)
      ChkModel: if (hit) pending_boxes = {pending_boxes, bx};
      ChkBox:   pending_boxes = {pending_boxes, typed};
      default: ;
    endcase
  endtask

  // Drop col valid, wait for every predicted box, then let the pipeline run dry.
  task automatic settle();
    col_if.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic write_settings(input logic [CfgW-1:0] lh, input logic [CfgW-1:0] gu,
                                input logic [CfgW-1:0] ir);
    cfg_reg_e idx;
    logic [CfgW-1:0] val;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0:       begin idx = CfgLineHeight; val = lh; end
        1:       begin idx = CfgGapUnit;    val = gu; end
        default: begin idx = CfgImageRows;  val = ir; end
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= '{reg_index: idx, wr_data: val};
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx)
        CfgLineHeight: cfg_line_height = val;
        CfgGapUnit:    cfg_gap_unit    = val;
        default:       cfg_image_rows  = val;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // One frame of glyphs and spaces in random bands, with some noise columns.
  task automatic send_frame(input int len);
    int          glyph_rem;
    int          space_rem;
    int          nr;
    int          band_top;
    int          band_h;
    logic [63:0] wide;
    logic [31:0] band;
    logic [31:0] m;
    calm      = ($urandom_range(0, 4) == 0);
    glyph_rem = 0;
    space_rem = $urandom_range(0, 3);
    nr        = (int'(cfg_image_rows) < int'(MaskW)) ? int'(cfg_image_rows) : int'(MaskW);
    band_top  = 0;
    band_h    = 1;
    band      = 32'h1;
    for (int c = 0; c < len; c++) begin
      if (glyph_rem == 0 && space_rem == 0) begin
        glyph_rem = $urandom_range(1, 6);
        space_rem = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
        band_top  = $urandom_range(0, nr - 1);
        band_h    = $urandom_range(1, nr - band_top);
        wide      = ((64'd1 << band_h) - 64'd1) << band_top;
        band      = wide[31:0];
      end
      if ($urandom_range(0, 9) == 0) begin
        m = $urandom;
      end else if (glyph_rem > 0) begin
        m = $urandom & band;
        if (m == 32'h0) m = 32'h1 << (band_top + $urandom_range(0, band_h - 1));
        glyph_rem--;
      end else begin
        // Empty column, sometimes with dark bits only in rows that are not in use.
        m = ($urandom_range(0, 3) == 0) ? ($urandom << nr) : 32'h0;
        space_rem--;
      end
      send_column(m, (c == len - 1), ChkModel, '0);
    end
  endtask

  // Apply one setting, then random frames until the item budget is spent.
  task automatic run_phase(input logic [CfgW-1:0] lh, input logic [CfgW-1:0] gu,
                           input logic [CfgW-1:0] ir, input int budget, input bit long_frame,
                           inout int sent);
    int len;
    int spent;
    settle();
    write_settings(lh, gu, ir);
    spent = 0;
    // Run past the column limit; boxes stay dense so the scan never stops.
    if (long_frame) begin
      send_frame(int'(MaxCols) + 16);
      spent = int'(MaxCols) + 16;
    end
    while (spent < budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
      send_frame(len);
      spent += len;
    end
    sent += spent;
  endtask

  initial begin
    int sent;
    err_count    = 0;
    cycle_count  = 0;
    rx_stall     = 0;
    calm         = 1'b0;
    sent         = 0;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    col_if.valid <= 1'b0;
    col_if.data  <= '0;
    cfg_line_height = LineHeightRst;
    cfg_gap_unit    = GapUnitRst;
    cfg_image_rows  = ImageRowsRst;
    clear_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings.
    foreach (directed_rows[i]) begin
      send_column(directed_rows[i].mask, directed_rows[i].last, directed_rows[i].chk,
                  directed_rows[i].box);
    end

    // Extremes first, then random settings.
    run_phase(6'd1, 6'd0, 6'd1, 150, 1'b0, sent);
    run_phase(6'd32, 6'd63, 6'd32, 150, 1'b1, sent);
    run_phase(6'd4, 6'd1, 6'd8, 150, 1'b0, sent);
    run_phase(6'd1, 6'd63, 6'd32, 100, 1'b0, sent);
    while (sent < int'(RandItems)) begin
      run_phase(CfgW'($urandom_range(1, 32)),
                ($urandom_range(0, 2) == 0) ? CfgW'($urandom_range(0, 63))
                                            : CfgW'($urandom_range(0, 3)),
                CfgW'($urandom_range(1, 32)), 150, 1'b0, sent);
    end

    // Drain: every box must arrive, and nothing may follow.
    settle();
    repeat (16) @(posedge clk_i);
    if (pending_boxes.size() != 0) begin
      $error("%0d predicted boxes never arrived", pending_boxes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_text_column_char_segmenter: PASS");
    end else begin
      $display("tb_text_column_char_segmenter: FAIL");
    end
    $finish;
  end

endmodule
